// File: rtl/mldc_pkg.sv
package mldc_pkg;

	localparam int MAP_W             = 50;
	localparam int LED_COUNT_DEFAULT = 50;

	localparam logic [5:0] NO_LED = 6'd50;

	localparam logic [6:0] VAL_OFF   = 7'd0;
	localparam logic [6:0] VAL_BLINK = 7'd32;
	localparam logic [6:0] VAL_BOTH  = 7'd64;

	localparam logic [3:0] KIND_NONE        = 4'd0;
	localparam logic [3:0] KIND_LED         = 4'd1;
	localparam logic [3:0] KIND_BAR_LEFT    = 4'd2;
	localparam logic [3:0] KIND_BAR_RIGHT   = 4'd3;
	localparam logic [3:0] KIND_DIGIT_LEFT  = 4'd4;
	localparam logic [3:0] KIND_DIGIT_RIGHT = 4'd5;
	localparam logic [3:0] KIND_LEVEL_LEFT  = 4'd6;
	localparam logic [3:0] KIND_LEVEL_RIGHT = 4'd7;
	localparam logic [3:0] KIND_COLOUR      = 4'd8;

	localparam logic [3:0] CH_DISPLAY = 4'd3;

	typedef struct packed {
		logic [3:0] channel_number;
		logic [6:0] control_number;
		logic [6:0] data_value;
	} midi_msg_t;

	typedef struct packed {
		logic [3:0]       update_kind;
		logic [MAP_W-1:0] lit_map;
		logic [MAP_W-1:0] flash_map;
		logic [7:0]       segment_first;
		logic [7:0]       segment_second;
		logic [4:0]       bar_amount;
		logic [6:0]       colour_index;
		logic [7:0]       red_level;
		logic [7:0]       green_level;
		logic [7:0]       blue_level;
	} led_update_t;

	typedef struct packed {
		logic       en;
		logic [5:0] idx;
		logic       lit;
		logic       flash;
	} led_cmd_t;

	localparam logic [5:0] LED_TABLE_0 [32] = '{
		6'd15, 6'd50, 6'd50, 6'd50, 6'd50, 6'd24, 6'd23, 6'd22,
		6'd29, 6'd1,  6'd32, 6'd31, 6'd30, 6'd8,  6'd7,  6'd50,
		6'd50, 6'd50, 6'd50, 6'd14, 6'd50, 6'd50, 6'd50, 6'd50,
		6'd13, 6'd9,  6'd10, 6'd50, 6'd40, 6'd39, 6'd38, 6'd33};

	localparam logic [5:0] LED_TABLE_1 [32] = '{
		6'd44, 6'd50, 6'd50, 6'd50, 6'd50, 6'd28, 6'd19, 6'd18,
		6'd17, 6'd1,  6'd27, 6'd26, 6'd25, 6'd2,  6'd1,  6'd50,
		6'd50, 6'd50, 6'd50, 6'd43, 6'd50, 6'd50, 6'd50, 6'd50,
		6'd48, 6'd49, 6'd41, 6'd50, 6'd35, 6'd36, 6'd37, 6'd11};

	localparam logic [5:0] LED_TABLE_2 [32] = '{
		6'd50, 6'd50, 6'd12, 6'd50, 6'd6,  6'd3,  6'd5,  6'd4,
		6'd16, 6'd21, 6'd20, 6'd34, 6'd47, 6'd46, 6'd45, 6'd42,
		6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
		6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50};

	// Each entry holds the first pattern byte in the upper half.
	localparam logic [15:0] DIGIT_PAIRS [11] = '{
		{8'd243, 8'd91},  {8'd162, 8'd221}, {8'd32, 8'd223}, {8'd32, 8'd150},
		{8'd32, 8'd91},   {8'd0, 8'd130},   {8'd0, 8'd91},   {8'd0, 8'd150},
		{8'd0, 8'd223},   {8'd130, 8'd221}, {8'd211, 8'd91}};

	// Red, green, blue from the upper byte down.
	localparam logic [23:0] COLOUR_RGB [7] = '{
		{8'd0, 8'd0, 8'd0},       {8'd0, 8'd0, 8'd255},   {8'd255, 8'd50, 8'd100},
		{8'd255, 8'd120, 8'd0},   {8'd255, 8'd150, 8'd0}, {8'd255, 8'd200, 8'd200},
		{8'd0, 8'd255, 8'd0}};

	// Remainder of a 7-bit value by a small constant through five restoring
	// compare-and-subtract steps.
	function automatic logic [6:0] mod_small(input logic [6:0] v, input logic [6:0] d);
		logic [10:0] r;
		logic [10:0] s;
		r = {4'b0, v};
		for (int i = 4; i >= 0; i--) begin
			s = {4'b0, d} << i;
			if (r >= s) begin
				r = r - s;
			end
		end
		return r[6:0];
	endfunction

endpackage

// File: rtl/mldc_decode.sv
module mldc_decode #(
	parameter int LED_COUNT = mldc_pkg::LED_COUNT_DEFAULT
) (
	input  mldc_pkg::midi_msg_t   msg,
	output mldc_pkg::led_cmd_t    cmd,
	output mldc_pkg::led_update_t info
);
	import mldc_pkg::*;

	logic [3:0] ch;
	logic [6:0] ctl;
	logic [6:0] val;
	logic [5:0] entry;
	logic [6:0] rem20;
	logic [6:0] rem11;
	logic [6:0] rem10;
	logic [6:0] rem7;
	logic [15:0] pair;
	logic [23:0] rgb;
	logic        led_ch;

	assign ch  = msg.channel_number;
	assign ctl = msg.control_number;
	assign val = msg.data_value;

	assign rem20 = mod_small(val, 7'd20);
	assign rem11 = mod_small(val, 7'd11);
	assign rem10 = mod_small(val, 7'd10);
	assign rem7  = mod_small(val, 7'd7);
	assign pair  = DIGIT_PAIRS[rem11[3:0]];
	assign rgb   = COLOUR_RGB[rem7[2:0]];

	assign led_ch = (ch[3:2] == 2'b00) && (ch[1:0] != 2'b11);

	always_comb begin
		case (ch[1:0])
			2'd0:    entry = LED_TABLE_0[ctl[4:0]];
			2'd1:    entry = LED_TABLE_1[ctl[4:0]];
			2'd2:    entry = LED_TABLE_2[ctl[4:0]];
			default: entry = NO_LED;
		endcase
	end

	always_comb begin
		cmd.idx   = entry;
		// Controls past the table address no LED.
		cmd.en    = led_ch && (ctl[6:5] == 2'b00) && (entry != NO_LED)
			&& (int'(entry) < LED_COUNT);
		cmd.lit   = 1'b1;
		cmd.flash = 1'b0;
		if (val == VAL_OFF) begin
			cmd.lit = 1'b0;
		end else if (val == VAL_BLINK) begin
			cmd.lit   = 1'b0;
			cmd.flash = 1'b1;
		end else if (val == VAL_BOTH) begin
			cmd.flash = 1'b1;
		end
	end

	always_comb begin
		info             = '0;
		info.update_kind = KIND_NONE;
		if (cmd.en) begin
			info.update_kind = KIND_LED;
		end else if (ch == CH_DISPLAY && ctl[6:4] == 3'b000) begin
			case (ctl[3:2])
				2'd0: begin
					info.update_kind = ctl[0] ? KIND_BAR_RIGHT : KIND_BAR_LEFT;
					info.bar_amount  = rem20[4:0];
				end
				2'd1: begin
					info.update_kind    = ctl[0] ? KIND_DIGIT_RIGHT : KIND_DIGIT_LEFT;
					info.segment_first  = pair[15:8];
					info.segment_second = pair[7:0];
				end
				2'd2: begin
					info.update_kind = ctl[0] ? KIND_LEVEL_RIGHT : KIND_LEVEL_LEFT;
					info.bar_amount  = rem10[4:0];
				end
				default: begin
					info.update_kind = KIND_NONE;
				end
			endcase
		end else if (ch[3:1] == 3'b010) begin
			info.update_kind  = KIND_COLOUR;
			info.colour_index = ctl;
			info.red_level    = rgb[23:16];
			info.green_level  = rgb[15:8];
			info.blue_level   = rgb[7:0];
		end
	end

endmodule

// File: rtl/mldc_led_maps.sv
module mldc_led_maps #(
	parameter int LED_COUNT = mldc_pkg::LED_COUNT_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mldc_pkg::led_cmd_t           cmd,
	input  logic                         commit,
	output logic [mldc_pkg::MAP_W-1:0]   lit_view,
	output logic [mldc_pkg::MAP_W-1:0]   flash_view
);
	import mldc_pkg::*;

	localparam int IdxW = $clog2(LED_COUNT);

	logic [LED_COUNT-1:0] lit_q;
	logic [LED_COUNT-1:0] flash_q;
	logic [LED_COUNT-1:0] lit_next;
	logic [LED_COUNT-1:0] flash_next;

	// The decoder only enables indexes below LED_COUNT.
	always_comb begin
		lit_next   = lit_q;
		flash_next = flash_q;
		if (cmd.en) begin
			lit_next[cmd.idx[IdxW-1:0]]   = cmd.lit;
			flash_next[cmd.idx[IdxW-1:0]] = cmd.flash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q   <= '0;
			flash_q <= '0;
		end else if (commit) begin
			lit_q   <= lit_next;
			flash_q <= flash_next;
		end
	end

	// The maps as they stand after this word, fitted to the result width.
	for (genvar i = 0; i < MAP_W; i++) begin : g_view
		if (i < LED_COUNT) begin : g_led
			assign lit_view[i]   = lit_next[i];
			assign flash_view[i] = flash_next[i];
		end else begin : g_pad
			assign lit_view[i]   = 1'b0;
			assign flash_view[i] = 1'b0;
		end
	end

endmodule

// File: rtl/midi_led_command_decoder_core.sv
// Flow: an accepted word is held in the input stage (msg_s1) and moves to the result
// register (rsp_q) when that frees up, raising rsp_valid (two register stages in all).
// Throughput: one word per cycle unless the receiver stalls; the LED map update is a
// single read-modify-write of the map registers in the decode stage.
// Reset: both LED maps clear to zero and both stages come up empty.
module midi_led_command_decoder_core #(
	parameter int LED_COUNT = mldc_pkg::LED_COUNT_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  mldc_pkg::midi_msg_t   req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output mldc_pkg::led_update_t rsp_data
);
	import mldc_pkg::*;

	midi_msg_t   msg_s1;
	logic        valid_s1;
	led_update_t rsp_q;
	logic        rsp_valid_q;

	led_cmd_t         cmd;
	led_update_t      info;
	logic [MAP_W-1:0] lit_view;
	logic [MAP_W-1:0] flash_view;
	logic             advance;
	logic             commit;
	led_update_t      result;

	// The result register frees up when empty or when taken this cycle.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign commit    = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	mldc_decode #(
		.LED_COUNT(LED_COUNT)
	) u_decode (
		.msg  (msg_s1),
		.cmd  (cmd),
		.info (info)
	);

	mldc_led_maps #(
		.LED_COUNT(LED_COUNT)
	) u_led_maps (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.commit     (commit),
		.lit_view   (lit_view),
		.flash_view (flash_view)
	);

	always_comb begin
		result           = info;
		result.lit_map   = lit_view;
		result.flash_map = flash_view;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			msg_s1 <= req_data;
		end
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mldc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam logic [3:0] CH_COLOUR_A = 4'd4;
	localparam logic [3:0] CH_COLOUR_B = 4'd5;

	// LED number for each (channel, control) pair on channels 0 to 2; 50 means no LED.
	localparam logic [5:0] LED_NUMBER [3][32] = '{
		'{6'd15, 6'd50, 6'd50, 6'd50, 6'd50, 6'd24, 6'd23, 6'd22,
		  6'd29, 6'd1,  6'd32, 6'd31, 6'd30, 6'd8,  6'd7,  6'd50,
		  6'd50, 6'd50, 6'd50, 6'd14, 6'd50, 6'd50, 6'd50, 6'd50,
		  6'd13, 6'd9,  6'd10, 6'd50, 6'd40, 6'd39, 6'd38, 6'd33},
		'{6'd44, 6'd50, 6'd50, 6'd50, 6'd50, 6'd28, 6'd19, 6'd18,
		  6'd17, 6'd1,  6'd27, 6'd26, 6'd25, 6'd2,  6'd1,  6'd50,
		  6'd50, 6'd50, 6'd50, 6'd43, 6'd50, 6'd50, 6'd50, 6'd50,
		  6'd48, 6'd49, 6'd41, 6'd50, 6'd35, 6'd36, 6'd37, 6'd11},
		'{6'd50, 6'd50, 6'd12, 6'd50, 6'd6,  6'd3,  6'd5,  6'd4,
		  6'd16, 6'd21, 6'd20, 6'd34, 6'd47, 6'd46, 6'd45, 6'd42,
		  6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
		  6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50}};

	localparam logic [7:0] SEG_BYTES [22] = '{
		8'd243, 8'd91, 8'd162, 8'd221, 8'd32, 8'd223, 8'd32, 8'd150, 8'd32, 8'd91,
		8'd0, 8'd130, 8'd0, 8'd91, 8'd0, 8'd150, 8'd0, 8'd223, 8'd130, 8'd221,
		8'd211, 8'd91};

	// Rows are red, green and blue.
	localparam logic [7:0] RGB_LEVELS [3][7] = '{
		'{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0},
		'{8'd0, 8'd0, 8'd50, 8'd120, 8'd150, 8'd200, 8'd255},
		'{8'd0, 8'd255, 8'd100, 8'd0, 8'd0, 8'd200, 8'd0}};

	class led_update_scoreboard;
		logic [MAP_W-1:0] lit_state;
		logic [MAP_W-1:0] flash_state;
		led_update_t      expected_q[$];
		int               mismatches;

		function new();
			lit_state = '0;
			flash_state = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Works out the update that one accepted message causes and queues it.
		function void note_message(midi_msg_t msg);
			led_update_t upd;
			logic [5:0]  led;
			logic [6:0]  ctl;
			logic [6:0]  val;
			int          pair;
			int          shade;
			upd = '0;
			ctl = msg.control_number;
			val = msg.data_value;
			if (msg.channel_number < CH_DISPLAY) begin
				if (ctl < 7'd32) begin
					led = LED_NUMBER[msg.channel_number[1:0]][ctl[4:0]];
					if (led != NO_LED && led < LED_COUNT_DEFAULT) begin
						lit_state[led] = !(val == VAL_OFF || val == VAL_BLINK);
						flash_state[led] = (val == VAL_BLINK || val == VAL_BOTH);
						upd.update_kind = KIND_LED;
					end
				end
			end else if (msg.channel_number == CH_DISPLAY) begin
				pair = (int'(val) % 11) * 2;
				case (ctl)
					7'd0, 7'd2: begin
						upd.update_kind = KIND_BAR_LEFT;
						upd.bar_amount = 5'(int'(val) % 20);
					end
					7'd1, 7'd3: begin
						upd.update_kind = KIND_BAR_RIGHT;
						upd.bar_amount = 5'(int'(val) % 20);
					end
					7'd4, 7'd6: begin
						upd.update_kind = KIND_DIGIT_LEFT;
						upd.segment_first = SEG_BYTES[pair];
						upd.segment_second = SEG_BYTES[pair + 1];
					end
					7'd5, 7'd7: begin
						upd.update_kind = KIND_DIGIT_RIGHT;
						upd.segment_first = SEG_BYTES[pair];
						upd.segment_second = SEG_BYTES[pair + 1];
					end
					7'd8, 7'd10: begin
						upd.update_kind = KIND_LEVEL_LEFT;
						upd.bar_amount = 5'(int'(val) % 10);
					end
					7'd9, 7'd11: begin
						upd.update_kind = KIND_LEVEL_RIGHT;
						upd.bar_amount = 5'(int'(val) % 10);
					end
					default: begin
					end
				endcase
			end else if (msg.channel_number == CH_COLOUR_A
					|| msg.channel_number == CH_COLOUR_B) begin
				shade = int'(val) % 7;
				upd.update_kind = KIND_COLOUR;
				upd.colour_index = ctl;
				upd.red_level = RGB_LEVELS[0][shade];
				upd.green_level = RGB_LEVELS[1][shade];
				upd.blue_level = RGB_LEVELS[2][shade];
			end
			upd.lit_map = lit_state;
			upd.flash_map = flash_state;
			expected_q.push_back(upd);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch in %s: expected %h, got %h", field, want, got);
				end
			end
		endfunction

		function void check_update(led_update_t got);
			led_update_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result word %h", got);
				end
				return;
			end
			want = expected_q.pop_front();
			compare_field("update_kind", 64'(want.update_kind), 64'(got.update_kind));
			compare_field("lit_map", 64'(want.lit_map), 64'(got.lit_map));
			compare_field("flash_map", 64'(want.flash_map), 64'(got.flash_map));
			compare_field("segment_first", 64'(want.segment_first), 64'(got.segment_first));
			compare_field("segment_second", 64'(want.segment_second),
				64'(got.segment_second));
			compare_field("bar_amount", 64'(want.bar_amount), 64'(got.bar_amount));
			compare_field("colour_index", 64'(want.colour_index), 64'(got.colour_index));
			compare_field("red_level", 64'(want.red_level), 64'(got.red_level));
			compare_field("green_level", 64'(want.green_level), 64'(got.green_level));
			compare_field("blue_level", 64'(want.blue_level), 64'(got.blue_level));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	midi_msg_t   req_data;
	logic        rsp_valid;
	logic        rsp_ready;
	led_update_t rsp_data;

	led_update_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_left;
	int cycle_count;

	midi_led_command_decoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		cycle_count = 0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				sb.note_message(req_data);
			end
			if (rsp_valid && rsp_ready) begin
				sb.check_update(rsp_data);
			end
		end
	end

	// The receiver either holds off for a counted stretch or stalls at random.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(input logic [3:0] ch, input logic [6:0] ctl,
			input logic [6:0] val);
		midi_msg_t msg;
		msg.channel_number = ch;
		msg.control_number = ctl;
		msg.data_value = val;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= msg;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly commands that reach a real LED, bar, digit or colour; the rest is noise.
	task automatic send_random_word();
		int          pick;
		logic [3:0]  ch;
		logic [6:0]  ctl;
		logic [6:0]  val;
		pick = $urandom_range(99);
		val = 7'($urandom_range(127));
		if (pick < 55) begin
			ch = 4'($urandom_range(2));
			ctl = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 32))
				: 7'($urandom_range(31));
			case ($urandom_range(3))
				0: val = VAL_OFF;
				1: val = VAL_BLINK;
				2: val = VAL_BOTH;
				default: begin
				end
			endcase
		end else if (pick < 75) begin
			ch = CH_DISPLAY;
			ctl = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 12))
				: 7'($urandom_range(11));
		end else if (pick < 92) begin
			ch = $urandom_range(1) ? CH_COLOUR_A : CH_COLOUR_B;
			ctl = 7'($urandom_range(127));
		end else begin
			ch = 4'($urandom_range(15, 6));
			ctl = 7'($urandom_range(127));
		end
		send_word(ch, ctl, val);
	endtask

	task automatic run_phase(input int count, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count) send_random_word();
		stop_sending();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(4'd0, 7'd0, 7'd127);
		send_word(4'd0, 7'd0, VAL_BLINK);
		send_word(4'd0, 7'd0, VAL_BOTH);
		send_word(4'd0, 7'd0, VAL_OFF);
		send_word(4'd1, 7'd25, 7'd1);
		send_word(4'd1, 7'd9, VAL_BOTH);
		send_word(4'd2, 7'd2, VAL_BOTH);
		send_word(4'd2, 7'd15, VAL_BLINK);
		// Table holes and controls past the end of the table leave the maps alone.
		send_word(4'd0, 7'd1, 7'd5);
		send_word(4'd2, 7'd31, 7'd127);
		send_word(4'd0, 7'd32, 7'd127);
		send_word(4'd2, 7'd127, VAL_BOTH);
		send_word(CH_DISPLAY, 7'd0, 7'd127);
		send_word(CH_DISPLAY, 7'd3, 7'd19);
		send_word(CH_DISPLAY, 7'd4, 7'd0);
		send_word(CH_DISPLAY, 7'd7, 7'd127);
		send_word(CH_DISPLAY, 7'd10, 7'd10);
		send_word(CH_DISPLAY, 7'd11, 7'd127);
		send_word(CH_DISPLAY, 7'd12, 7'd5);
		send_word(CH_DISPLAY, 7'd127, 7'd0);
		send_word(CH_COLOUR_A, 7'd0, 7'd0);
		send_word(CH_COLOUR_B, 7'd127, 7'd127);
		send_word(4'd6, 7'd5, 7'd5);
		send_word(4'd15, 7'd127, 7'd127);
		stop_sending();
		wait_drained();

		run_phase(240, 0, 0);
		wait_drained();
		run_phase(240, 68, 0);
		run_phase(240, 0, 68);
		run_phase(240, 9, 9);

		// Long receiver hold-off while words keep coming, so the input backs up.
		hold_left = 300;
		run_phase(60, 0, 0);
		wait_drained();
		run_phase(60, 0, 0);
		wait_drained();

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
